// ===== sv/ssgm_pkg.sv =====
`timescale 1ns / 1ps
package ssgm_pkg;

  typedef struct packed {
    logic signed [15:0] bin_real;
    logic signed [15:0] bin_imag;
    logic [31:0]        noise_power;
  } bin_beat_t;

  typedef struct packed {
    logic [15:0] gain_mask;
    logic [31:0] snr_estimate;
    logic        frame_last;
  } mask_beat_t;

  typedef enum logic [1:0] {
    CFG_BINS_IN_USE        = 2'd0,
    CFG_ALPHA_P            = 2'd1,
    CFG_NOISE_FLOOR_OFFSET = 2'd2
  } cfg_reg_t;

  localparam logic [9:0]  BINS_RESET  = 10'd257;
  localparam logic [15:0] ALPHA_RESET = 16'd6554;
  localparam logic [31:0] EPS_RESET   = 32'd1;

  // Q1.16 unity, and Q16.16 saturation value
  localparam logic [16:0] ONE_Q16 = 17'h10000;
  localparam logic [31:0] XI_MAX  = 32'hFFFF_FFFF;

endpackage

// ===== sv/ssgm_div_pipe.sv =====
`timescale 1ns / 1ps
module ssgm_div_pipe #(
  parameter int QW = 32,
  parameter int DW = 33,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_bits,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  // one restoring step per stage; numerator bits shift out as quotient bits shift in
  logic          v_q    [QW];
  logic [DW-1:0] rem_q  [QW];
  logic [QW-1:0] bits_q [QW];
  logic [DW-1:0] den_q  [QW];
  logic [SW-1:0] side_q [QW];

  genvar i;
  for (i = 0; i < QW; i++) begin : g_step
    logic          v_in;
    logic [DW-1:0] r_in;
    logic [QW-1:0] b_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [DW:0]   r_ext;
    logic          ge;
    logic [DW:0]   diff;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = in_rem;
      assign b_in = in_bits;
      assign d_in = in_den;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = v_q[i-1];
      assign r_in = rem_q[i-1];
      assign b_in = bits_q[i-1];
      assign d_in = den_q[i-1];
      assign s_in = side_q[i-1];
    end

    assign r_ext = {r_in, b_in[QW-1]};
    assign ge    = r_ext >= {1'b0, d_in};
    assign diff  = r_ext - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i]  <= ge ? diff[DW-1:0] : r_ext[DW-1:0];
        bits_q[i] <= {b_in[QW-2:0], ge};
        den_q[i]  <= d_in;
        side_q[i] <= s_in;
      end
    end
  end

  assign out_valid = v_q[QW-1];
  assign out_quo   = bits_q[QW-1];
  assign out_side  = side_q[QW-1];

endmodule

// ===== sv/spectral_snr_gain_mask_unit.sv =====
`timescale 1ns / 1ps
// Each bin beat passes s0 to s5, the xi divider, s6, the gain divider and
// the output register. Throughput: one bin per cycle while the output is not
// stalled and the frame holds more bins than in flight (55); a shorter frame
// waits: a bin's gain is read only after the previous frame wrote it back to RAM.
// Reset (rst, synchronous): registers return to their defaults, then a clearing
// pass zeroes all MAX_BINS gain RAM entries one entry a cycle with bins stalled.
module spectral_snr_gain_mask_unit #(
  parameter int MAX_BINS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  bin_valid,
  output logic                  bin_stall,
  input  ssgm_pkg::bin_beat_t   bin_data,
  output logic                  mask_valid,
  input  logic                  mask_stall,
  output ssgm_pkg::mask_beat_t  mask_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);
  import ssgm_pkg::*;

  localparam int IW    = $clog2(MAX_BINS);
  localparam int CW    = $clog2(MAX_BINS + 1);
  localparam int OCC_W = 7;  // holds the in-flight count (up to 55)
  localparam int SIDE1 = IW + 3;
  localparam int SIDE2 = IW + 33;

  // ---------------- configuration registers ----------------
  logic [9:0]  bins_in_use;
  logic [15:0] alpha_p;
  logic [31:0] noise_floor_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use        <= BINS_RESET;
      alpha_p            <= ALPHA_RESET;
      noise_floor_offset <= EPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BINS_IN_USE:        bins_in_use        <= cfg_data[9:0];
        CFG_ALPHA_P:            alpha_p            <= cfg_data[15:0];
        CFG_NOISE_FLOOR_OFFSET: noise_floor_offset <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Effective frame length: zero acts as one, clamp to the RAM depth.
  logic [31:0]   bins_ext;
  logic [CW-1:0] n_bins;

  assign bins_ext = 32'(bins_in_use);

  always_comb begin
    if (bins_ext == 32'd0) begin
      n_bins = CW'(1);
    end else if (bins_ext > 32'(MAX_BINS)) begin
      n_bins = CW'(MAX_BINS);
    end else begin
      n_bins = bins_ext[CW-1:0];
    end
  end

  // ---------------- control: clearing pass, interlock, bin counter ----------------
  logic          adv;          // whole pipeline moves one step
  logic          accept;
  logic          clr_busy;
  logic [CW-1:0] clr_addr;
  logic [IW-1:0] bin_counter;
  logic [OCC_W-1:0] occ;       // beats accepted whose gain is not yet written back
  logic          last_now;
  logic          wb;           // gain write-back of the beat leaving the pipeline

  assign adv    = !mask_valid || !mask_stall;
  // Hold input while the RAM clears, while the output is stalled, and while a
  // full frame is in flight (the next bin's gain would still be pending).
  assign bin_stall = clr_busy || !adv || (32'(occ) >= 32'(n_bins));
  assign accept = bin_valid && !bin_stall;
  assign last_now = 32'(bin_counter) >= (32'(n_bins) - 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy    <= 1'b1;
      clr_addr    <= '0;
      bin_counter <= '0;
      occ         <= '0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + CW'(1);
        if (32'(clr_addr) == 32'(MAX_BINS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (accept) begin
        bin_counter <= last_now ? '0 : bin_counter + IW'(1);
      end
      if (accept && !wb) begin
        occ <= occ + OCC_W'(1);
      end else if (!accept && wb) begin
        occ <= occ - OCC_W'(1);
      end
    end
  end

  // ---------------- gain RAM ----------------
  logic [15:0]   gain_mem [MAX_BINS];
  logic [15:0]   rd_gain;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   d2_quo;
  logic [SIDE2-1:0] d2_side;
  logic          d2_valid;

  assign wb = d2_valid && adv;

  always_comb begin
    if (clr_busy) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr[IW-1:0];
      mem_wdata = '0;
    end else begin
      mem_we    = wb;
      mem_waddr = d2_side[SIDE2-1 -: IW];
      mem_wdata = d2_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      gain_mem[mem_waddr] <= mem_wdata;
    end
    if (adv) begin
      rd_gain <= gain_mem[bin_counter];
    end
  end

  // ---------------- front stages ----------------
  logic          s0_valid, s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic signed [15:0] s0_re, s0_im;
  logic [32:0]   s0_den, s1_den, s2_den, s3_den, s4_den, s5_den;
  logic [IW-1:0] s0_idx, s1_idx, s2_idx, s3_idx, s4_idx, s5_idx;
  logic          s0_last, s1_last, s2_last, s3_last, s4_last, s5_last;
  logic signed [31:0] s1_sq_re, s1_sq_im;
  logic [31:0]   s1_gg;
  logic [31:0]   s2_power, s3_power;
  logic [16:0]   s2_w;
  logic [16:0]   s3_weight;
  logic [48:0]   s4_num, s5_num;
  logic          s5_ovf, s5_zero;
  logic [16:0]   one_minus_alpha;
  logic [48:0]   w_prod;

  assign one_minus_alpha = ONE_Q16 - {1'b0, alpha_p};
  assign w_prod = {32'b0, one_minus_alpha} * {17'b0, s1_gg};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= accept;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // capture the beat; the RAM read of its gain lands alongside
      s0_re   <= bin_data.bin_real;
      s0_im   <= bin_data.bin_imag;
      s0_den  <= {1'b0, bin_data.noise_power} + {1'b0, noise_floor_offset};
      s0_idx  <= bin_counter;
      s0_last <= last_now;
      // squares and g^2
      s1_sq_re <= s0_re * s0_re;
      s1_sq_im <= s0_im * s0_im;
      s1_gg    <= {16'b0, rd_gain} * {16'b0, rd_gain};
      s1_den   <= s0_den;
      s1_idx   <= s0_idx;
      s1_last  <= s0_last;
      // power, and (1 - alpha) * g^2 truncated to Q0.16
      s2_power <= $unsigned(s1_sq_re) + $unsigned(s1_sq_im);
      s2_w     <= w_prod[48:32];
      s2_den   <= s1_den;
      s2_idx   <= s1_idx;
      s2_last  <= s1_last;
      // weight = w + alpha
      s3_weight <= s2_w + {1'b0, alpha_p};
      s3_power  <= s2_power;
      s3_den    <= s2_den;
      s3_idx    <= s2_idx;
      s3_last   <= s2_last;
      // numerator of xi
      s4_num  <= {32'b0, s3_weight} * {17'b0, s3_power};
      s4_den  <= s3_den;
      s4_idx  <= s3_idx;
      s4_last <= s3_last;
      // saturation check: quotient >= 2^32 (covers a zero denominator too)
      s5_num  <= s4_num;
      s5_den  <= s4_den;
      s5_ovf  <= {16'b0, s4_num} >= {s4_den, 32'b0};
      s5_zero <= s4_num == 49'd0;
      s5_idx  <= s4_idx;
      s5_last <= s4_last;
    end
  end

  // ---------------- xi = num / den, 32 quotient bits ----------------
  logic             d1_valid;
  logic [31:0]      d1_quo;
  logic [SIDE1-1:0] d1_side;
  logic [31:0]      xi;

  ssgm_div_pipe #(
    .QW(32),
    .DW(33),
    .SW(SIDE1)
  ) u_div_xi (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s5_valid),
    .in_rem   ({16'b0, s5_num[48:32]}),
    .in_bits  (s5_num[31:0]),
    .in_den   (s5_den),
    .in_side  ({s5_idx, s5_last, s5_ovf, s5_zero}),
    .out_valid(d1_valid),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  always_comb begin
    if (d1_side[0]) begin
      xi = '0;
    end else if (d1_side[1]) begin
      xi = XI_MAX;
    end else begin
      xi = d1_quo;
    end
  end

  // ---------------- gain = (xi << 16) / (xi + 1.0) ----------------
  logic          s6_valid;
  logic [31:0]   s6_xi;
  logic [32:0]   s6_den2;
  logic [IW-1:0] s6_idx;
  logic          s6_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (adv) begin
      s6_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_xi   <= xi;
      s6_den2 <= {1'b0, xi} + {16'b0, ONE_Q16};
      s6_idx  <= d1_side[SIDE1-1 -: IW];
      s6_last <= d1_side[2];
    end
  end

  ssgm_div_pipe #(
    .QW(16),
    .DW(33),
    .SW(SIDE2)
  ) u_div_gain (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (s6_valid),
    .in_rem   ({1'b0, s6_xi}),
    .in_bits  (16'b0),
    .in_den   (s6_den2),
    .in_side  ({s6_idx, s6_last, s6_xi}),
    .out_valid(d2_valid),
    .out_quo  (d2_quo),
    .out_side (d2_side)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= 1'b0;
    end else if (adv) begin
      mask_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mask_data.gain_mask    <= d2_quo;
      mask_data.snr_estimate <= d2_side[31:0];
      mask_data.frame_last   <= d2_side[32];
    end
  end

endmodule

// ===== sv/ssgm_checker.sv =====
`timescale 1ns / 1ps
module ssgm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 bin_stall,
  input logic                 mask_valid,
  input logic                 mask_stall,
  input ssgm_pkg::mask_beat_t mask_data
);
  import ssgm_pkg::*;

  // a stalled mask beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    mask_valid && mask_stall |=> mask_valid && $stable(mask_data))
    else $error("mask beat changed while stalled");

  // the gain RAM clears after reset before any bin is taken
  a_clear: assert property (@(posedge clk) rst |=> bin_stall)
    else $error("bin taken during gain clear");

  // zero SNR gives zero gain
  a_zero: assert property (@(posedge clk) disable iff (rst)
    mask_valid && mask_data.snr_estimate == 32'd0 |-> mask_data.gain_mask == 16'd0)
    else $error("nonzero gain with zero snr");

  // SNR of one or more gives gain of one half or more
  a_half: assert property (@(posedge clk) disable iff (rst)
    mask_valid && mask_data.snr_estimate >= 32'h0001_0000 |->
      mask_data.gain_mask >= 16'h8000)
    else $error("gain below one half at snr above one");

endmodule

bind spectral_snr_gain_mask_unit ssgm_checker u_ssgm_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ssgm_pkg::*;

  localparam int MAX_BINS = 512;
  localparam int LATENCY = 55;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic bin_valid = 1'b0;
  logic bin_stall;
  bin_beat_t bin_data = '0;
  logic mask_valid;
  logic mask_stall = 1'b0;
  mask_beat_t mask_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  spectral_snr_gain_mask_unit #(.MAX_BINS(MAX_BINS)) dut (
    .clk(clk), .rst(rst),
    .bin_valid(bin_valid), .bin_stall(bin_stall), .bin_data(bin_data),
    .mask_valid(mask_valid), .mask_stall(mask_stall), .mask_data(mask_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: registers, gain store and bin counter.
  logic [9:0] bins_reg;
  logic [15:0] alpha_reg;
  logic [31:0] eps_reg;
  logic [15:0] gain_store[MAX_BINS];
  int unsigned bin_pos;

  mask_beat_t mask_queue[$];
  int errors = 0;
  longint cycles = 0;

  // Idle levels in percent; hold_off forces a long receiver stall.
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_off = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("tb: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Compute the mask for one bin and advance the shadow state.
  function automatic mask_beat_t wiener_gain(input bin_beat_t b);
    mask_beat_t r;
    int unsigned n, idx;
    logic last;
    logic signed [31:0] re, im;
    logic [63:0] pw, g, w, weight, num, den, xi, gn;
    n = (bins_reg == 0) ? 1 : (bins_reg > MAX_BINS ? MAX_BINS : bins_reg);
    idx = (bin_pos >= MAX_BINS) ? 0 : bin_pos;
    last = (idx >= n - 1);
    re = b.bin_real;
    im = b.bin_imag;
    pw = 64'(re * re) + 64'(im * im);
    g = gain_store[idx];
    w = ((64'd65536 - alpha_reg) * g * g) >> 32;
    weight = w + alpha_reg;
    num = weight * pw;
    den = 64'(b.noise_power) + 64'(eps_reg);
    if (den == 0) xi = (num != 0) ? 64'hFFFF_FFFF : 64'd0;
    else xi = num / den;
    if (xi > 64'hFFFF_FFFF) xi = 64'hFFFF_FFFF;
    gn = (xi << 16) / (xi + 64'd65536);
    gain_store[idx] = gn[15:0];
    bin_pos = last ? 0 : idx + 1;
    r.gain_mask = gn[15:0];
    r.snr_estimate = xi[31:0];
    r.frame_last = last;
    return r;
  endfunction

  // Drive one bin beat and hold it until accepted; valid stays up for the
  // next beat unless the sender idles.
  task automatic send_bin(input bin_beat_t b);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      bin_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    bin_valid <= 1'b1;
    bin_data <= b;
    do @(posedge clk); while (bin_stall);
    mask_queue.push_back(wiener_gain(b));
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BINS_IN_USE: bins_reg = val[9:0];
      CFG_ALPHA_P: alpha_reg = val[15:0];
      CFG_NOISE_FLOOR_OFFSET: eps_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    bin_valid <= 1'b0;
    while (mask_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // Receiver: stall at random, and hold off entirely while hold_off is set.
  always @(posedge clk) begin
    if (rst) mask_stall <= 1'b0;
    else mask_stall <= hold_off || (recv_idle > 0 && $urandom_range(99) < recv_idle);
  end

  // Check each accepted mask beat against the oldest prediction.
  always @(posedge clk) begin
    mask_beat_t want;
    if (!rst && mask_valid && !mask_stall) begin
      if (mask_queue.size() == 0) begin
        errors++;
        $display("tb: unexpected mask beat at %0t", $realtime);
      end else begin
        want = mask_queue.pop_front();
        if (mask_data.gain_mask !== want.gain_mask)
          report("gain_mask", mask_data.gain_mask, want.gain_mask);
        if (mask_data.snr_estimate !== want.snr_estimate)
          report("snr_estimate", mask_data.snr_estimate, want.snr_estimate);
        if (mask_data.frame_last !== want.frame_last)
          report("frame_last", mask_data.frame_last, want.frame_last);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Directed rows; the expected beat is checked only where check is set.
  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [31:0] noise;
    bit check;
    mask_beat_t want;
  } bin_row_t;

  function automatic bin_beat_t random_bin();
    bin_beat_t b;
    b.bin_real = 16'($urandom);
    b.bin_imag = 16'($urandom);
    case ($urandom_range(3))
      0: b.noise_power = $urandom;
      1: b.noise_power = $urandom_range(65535);
      2: b.noise_power = $urandom_range(16);
      default: b.noise_power = 32'hFFFF_FFFF - $urandom_range(3);
    endcase
    if ($urandom_range(9) == 0) begin
      b.bin_real = 16'($urandom_range(7) - 4);
      b.bin_imag = 16'($urandom_range(7) - 4);
    end
    return b;
  endfunction

  initial begin
    bin_row_t rows[$];
    bin_beat_t b;
    int phase;
    bins_reg = BINS_RESET;
    alpha_reg = ALPHA_RESET;
    eps_reg = EPS_RESET;
    foreach (gain_store[i]) gain_store[i] = '0;
    bin_pos = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset, zero input gives zero; a noiseless bin with gain zero
    // has weight alpha and exact xi.
    rows.push_back('{16'sd0, 16'sd0, 32'd0, 1, '{16'd0, 32'd0, 1'b0}});
    rows.push_back('{16'sd1, 16'sd0, 32'd0, 1, '{16'd5958, 32'd6554, 1'b0}});
    rows.push_back('{-16'sd32768, -16'sd32768, 32'hFFFF_FFFF, 0, '{default:'0}});
    rows.push_back('{16'sd32767, -16'sd32768, 32'd0, 0, '{default:'0}});
    rows.push_back('{16'sd32767, 16'sd32767, 32'd1, 0, '{default:'0}});
    rows.push_back('{-16'sd1, -16'sd1, 32'hFFFF_FFFE, 0, '{default:'0}});
    foreach (rows[i]) begin
      b.bin_real = rows[i].re;
      b.bin_imag = rows[i].im;
      b.noise_power = rows[i].noise;
      send_bin(b);
      if (rows[i].check && mask_queue[$] !== rows[i].want) begin
        errors++;
        $display("tb: directed row %0d predicts wrong", i);
      end
    end
    drain();

    // Zero denominator: epsilon zero plus noise zero, and the wrap of
    // noise plus epsilon does not reach zero in 64 bits.
    write_reg(CFG_NOISE_FLOOR_OFFSET, 32'd0);
    write_reg(CFG_ALPHA_P, 32'd65535);
    write_reg(CFG_BINS_IN_USE, 32'd0);
    b = '{16'sd3, 16'sd4, 32'd0};
    send_bin(b);
    b = '{16'sd0, 16'sd0, 32'd0};
    send_bin(b);
    drain();
    write_reg(CFG_NOISE_FLOOR_OFFSET, 32'hFFFF_FFFF);
    b = '{16'sd32767, 16'sd32767, 32'hFFFF_FFFF};
    send_bin(b);
    drain();
    // Bin count above the maximum, then shrunk mid-frame.
    write_reg(CFG_BINS_IN_USE, 32'd1023);
    write_reg(CFG_ALPHA_P, 32'd0);
    write_reg(CFG_NOISE_FLOOR_OFFSET, 32'd1);
    repeat (8) send_bin(random_bin());
    drain();
    write_reg(CFG_BINS_IN_USE, 32'd3);
    repeat (4) send_bin(random_bin());
    drain();

    // Random part: several settings and idle phases.
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 82; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 82; end
        default: begin send_idle = 36; recv_idle = 36; end
      endcase
      case (phase)
        0: write_reg(CFG_BINS_IN_USE, 32'd512);
        1: write_reg(CFG_BINS_IN_USE, 32'd1);
        2: write_reg(CFG_BINS_IN_USE, 32'd64);
        default: write_reg(CFG_BINS_IN_USE, $urandom_range(80, 1));
      endcase
      write_reg(CFG_ALPHA_P, phase == 4 ? 32'd65535 : $urandom_range(65535));
      write_reg(CFG_NOISE_FLOOR_OFFSET, phase == 5 ? 32'hFFFF_FFFF :
                (phase == 6 ? 32'd0 : $urandom_range(1000)));
      if (phase == 0) begin
        // Hold the receiver off while bins keep arriving.
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
          repeat (200) send_bin(random_bin());
        join
      end else begin
        repeat (phase == 1 ? 40 : 120) send_bin(random_bin());
      end
      drain();
    end

    send_idle = 0;
    recv_idle = 0;
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
